// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadByte = 8'h80;

	// Word handed from the front to the back: one full block.
	typedef struct packed {
		logic [15:0][31:0] words;
		logic              final_blk;
	} blk_t;

	typedef enum logic [1:0] {
		FR_FILL,
		FR_PAD,
		FR_LEN
	} front_state_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ROUND,
		BK_ADD,
		BK_OUT
	} back_state_t;

	function automatic logic [31:0] ror(input logic [31:0] x, input int r);
		ror = (x >> r) | (x << (32 - r));
	endfunction

endpackage

// ===== rtl/core/sha256_front.sv =====
module sha256_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            data_byte,
	input  logic                  has_byte,
	input  logic                  end_of_message,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  blk_valid,
	output sha256_pkg::blk_t      blk,
	input  logic                  blk_stall
);
	import sha256_pkg::*;

	front_state_t      state_q, state_d;
	logic [15:0][31:0] words_q;
	logic [5:0]        cnt_q;
	logic [63:0]       len_q;
	logic              pend_q;
	logic              full_q;
	logic              fin_q;

	logic        take;
	logic        push_en;
	logic [7:0]  push_byte;
	logic [5:0]  pos;

	assign pos = cnt_q;
	// The output block register must be free before anything is pushed.
	assign in_stall = full_q || (state_q != FR_FILL) || pend_q;
	assign take     = in_valid && !in_stall;

	// Next state; the pad byte may already have landed on byte 55
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_FILL: if (pend_q && !full_q) state_d = FR_PAD;
			FR_PAD:  if (!full_q && (cnt_q == 6'd55 || cnt_q == 6'd56)) state_d = FR_LEN;
			FR_LEN:  if (!full_q) state_d = FR_FILL;
			default: state_d = FR_FILL;
		endcase
	end

	// Byte source for the block register
	always_comb begin
		push_en   = 1'b0;
		push_byte = 8'h00;
		unique case (state_q)
			FR_FILL: begin
				if (pend_q && !full_q) begin
					push_en   = 1'b1;
					push_byte = PadByte;
				end else if (take && has_byte) begin
					push_en   = 1'b1;
					push_byte = data_byte;
				end
			end
			FR_PAD:  push_en = !full_q && cnt_q != 6'd56;
			default: push_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_FILL;
			cnt_q   <= '0;
			len_q   <= '0;
			pend_q  <= 1'b0;
			full_q  <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (full_q && !blk_stall) full_q <= 1'b0;
			if (take && has_byte) len_q <= len_q + 64'd8;
			if (take && end_of_message) pend_q <= 1'b1;
			if (state_q == FR_FILL && pend_q && !full_q) pend_q <= 1'b0;
			if (push_en) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					full_q <= 1'b1;
					fin_q  <= 1'b0;
				end
			end
			if (state_q == FR_LEN && !full_q) begin
				full_q <= 1'b1;
				fin_q  <= 1'b1;
				cnt_q  <= '0;
				len_q  <= '0;
			end
		end
	end

	// Block payload
	always_ff @(posedge clk) begin
		if (push_en) begin
			if (pos[1:0] == 2'd0)
				words_q[pos[5:2]] <= {push_byte, 24'h0};
			else
				words_q[pos[5:2]][8'd31 - {pos[1:0], 3'd0} -: 8] <= push_byte;
		end
		if (state_q == FR_LEN && !full_q) begin
			words_q[14] <= len_q[63:32];
			words_q[15] <= len_q[31:0];
		end
	end

	assign blk_valid      = full_q;
	assign blk.words      = words_q;
	assign blk.final_blk  = fin_q;

endmodule

// ===== rtl/core/sha256_back.sv =====
module sha256_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             blk_valid,
	input  sha256_pkg::blk_t blk,
	output logic             blk_stall,
	output logic [31:0]      digest_word,
	output logic             last_word,
	output logic             out_valid,
	input  logic             out_stall
);
	import sha256_pkg::*;

	back_state_t       state_q, state_d;
	logic [7:0][31:0]  h_q;
	logic [7:0][31:0]  v_q;
	logic [15:0][31:0] w_q;
	logic [5:0]        rnd_q;
	logic [2:0]        oidx_q;
	logic              fin_q;

	logic        take;
	logic [31:0] s0, s1, wnext, big0, big1, ch, maj, t1, t2;

	assign blk_stall = state_q != BK_IDLE;
	assign take      = blk_valid && state_q == BK_IDLE;
	assign out_valid = state_q == BK_OUT;
	assign digest_word = h_q[oidx_q];
	assign last_word   = oidx_q == 3'd7;

	// Schedule and round datapath
	always_comb begin
		s0    = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1    = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wnext = w_q[0] + s0 + w_q[9] + s1;
		big1  = ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25);
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1    = v_q[7] + big1 + ch + RoundK[rnd_q] + w_q[0];
		big0  = ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2    = big0 + maj;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (take) state_d = BK_ROUND;
			BK_ROUND: if (rnd_q == 6'd63) state_d = BK_ADD;
			BK_ADD:   state_d = fin_q ? BK_OUT : BK_IDLE;
			BK_OUT:   if (!out_stall && oidx_q == 3'd7) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			rnd_q   <= '0;
			oidx_q  <= '0;
			fin_q   <= 1'b0;
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else begin
			state_q <= state_d;
			if (take) begin
				fin_q <= blk.final_blk;
				rnd_q <= '0;
			end
			if (state_q == BK_ROUND) rnd_q <= rnd_q + 6'd1;
			if (state_q == BK_ADD)
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			if (state_q == BK_OUT && !out_stall) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'd7)
					for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
			end
		end
	end

	// Working variables and schedule window; word 0 is the first of the block
	always_ff @(posedge clk) begin
		if (take) begin
			w_q <= blk.words;
			v_q <= h_q;
		end else if (state_q == BK_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= wnext;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule

// ===== rtl/core/sha256_message_hasher.sv =====
// SHA-256 hasher, one message byte per input word.
// Input channel: data_byte/has_byte/end_of_message with in_valid/in_stall.
// A word with has_byte set appends data_byte; end_of_message closes the
// message (after its byte, if any). An idle word changes nothing.
// Output channel: eight words digest_word H0..H7, last_word on H7,
// with out_valid/out_stall.
// Front: packs bytes into a 64-byte block register, then pads (one pad byte
// per cycle while the block register is free) and inserts the bit length.
// A full block register is the queue toward the back; the front stalls while
// it is occupied. Back: 64 rounds, one per cycle, then one hash update.
// Bytes take one cycle each while the block register is free, also while the
// back works on the previous block.
// After end_of_message the digest follows padding, one or two compressions,
// then eight words, held while out_stall is high.
// Reset restores the initial hash and empties all queues.
module sha256_message_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        end_of_message,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [31:0] digest_word,
	output logic        last_word,
	output logic        out_valid,
	input  logic        out_stall
);
	import sha256_pkg::*;

	blk_t blk;
	logic blk_valid, blk_stall;

	sha256_front u_front (
		.clk, .arst_n, .data_byte, .has_byte, .end_of_message,
		.in_valid, .in_stall, .blk_valid, .blk, .blk_stall
	);

	sha256_back u_back (
		.clk, .arst_n, .blk_valid, .blk, .blk_stall,
		.digest_word, .last_word, .out_valid, .out_stall
	);

	// A queued block stays until the back takes it.
	a_blk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		blk_valid && blk_stall |=> blk_valid)
		else $error("queued block dropped");

	// Once the last word is taken, results are no longer offered.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		last_word && out_valid && !out_stall |=> !out_valid)
		else $error("digest overrun");

endmodule
